[rtl/core/tsct_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tsct_pkg
// Shared types and codes for the tick-sorted command table.
// ----------------------------------------------------------------------------
package tsct_pkg;

  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_OP    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_RD_LAST,
    DP_SRCH_INIT,
    DP_RD_MID,
    DP_SRCH_UPD,
    DP_SH_START,
    DP_SH_STEP,
    DP_INSERT,
    DP_APPEND,
    DP_RD_LO,
    DP_CLEAR,
    DP_FIND_HIT
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_LAST,
    S_SRCH,
    S_SCHK,
    S_SHIFT,
    S_INSERT,
    S_FCHK
  } state_e;

  typedef struct packed {
    logic [31:0]        tick;
    logic signed [7:0]  forward;
    logic signed [7:0]  strafe;
    logic signed [7:0]  turn;
    logic signed [7:0]  look;
    logic [31:0]        buttons;
    logic [31:0]        sequence_num;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    dp_op_e  op;
    logic    resp;
    status_e status;
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic empty;
    logic older;
    logic srch_done;
    logic lo_in;
    logic tick_eq;
    logic sh_done;
  } sts_t;

endpackage
`default_nettype wire

[rtl/core/tick_sorted_command_table_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tick_sorted_command_table_unit
// Table of command records kept in tick order, with find and clear.
// ----------------------------------------------------------------------------
// One command is taken when start is high and busy is low; its result shows
// for one cycle with result_strobe_o high and must be captured then. All
// work goes through an entry memory with a registered read. Clear, a dropped
// record, an unknown operation and an append to an empty table answer from
// the dispatch state, other appends after a read of the last entry. A find
// runs a binary search (a read of the middle entry and a compare per step),
// then reads the entry at the lower bound to check its tick unless the
// search ran past the last entry. An out of order record reads the last
// entry, searches for its slot the same way, then moves each later entry up
// one slot per cycle and inserts. No clearing pass after reset; the table
// starts empty.
// ----------------------------------------------------------------------------
module tick_sorted_command_table_unit #(
  parameter int CAPACITY = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        cmd_i,
  input  wire logic [31:0]       tick_i,
  input  wire logic signed [7:0] forward_i,
  input  wire logic signed [7:0] strafe_i,
  input  wire logic signed [7:0] turn_i,
  input  wire logic signed [7:0] look_i,
  input  wire logic [31:0]       buttons_i,
  input  wire logic [31:0]       sequence_req_i,
  output logic                   result_strobe_o,
  output logic [1:0]             status_o,
  output logic signed [7:0]      found_forward_o,
  output logic signed [7:0]      found_strafe_o,
  output logic signed [7:0]      found_turn_o,
  output logic signed [7:0]      found_look_o,
  output logic [31:0]            found_buttons_o,
  output logic [31:0]            found_sequence_o,
  output logic [6:0]             entry_count_o
);
  import tsct_pkg::*;

  ctrl_t  ctrl;
  sts_t   sts;
  entry_t entry_in;
  entry_t found;

  assign entry_in.tick         = tick_i;
  assign entry_in.forward      = forward_i;
  assign entry_in.strafe       = strafe_i;
  assign entry_in.turn         = turn_i;
  assign entry_in.look         = look_i;
  assign entry_in.buttons      = buttons_i;
  assign entry_in.sequence_num = sequence_req_i;

  tsct_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .strobe_o (result_strobe_o),
    .sts_i    (sts),
    .ctrl_o   (ctrl)
  );

  tsct_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_i),
    .entry_i  (entry_in),
    .ctrl_i   (ctrl),
    .sts_o    (sts),
    .status_o (status_o),
    .found_o  (found),
    .count_o  (entry_count_o)
  );

  assign found_forward_o  = found.forward;
  assign found_strafe_o   = found.strafe;
  assign found_turn_o     = found.turn;
  assign found_look_o     = found.look;
  assign found_buttons_o  = found.buttons;
  assign found_sequence_o = found.sequence_num;

  a_strobe_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(busy))
    else $error("result without a command in flight");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  a_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && status_o != ST_OK |->
      found_buttons_o == '0 && found_sequence_o == '0)
    else $error("found fields set on a failed command");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && status_o == ST_FULL |-> entry_count_o == 7'(CAPACITY))
    else $error("record dropped while table not full");

endmodule
`default_nettype wire

[rtl/core/tsct_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tsct_ctrl
// Sequencer for record, find and clear: binary search, shift, insert.
// ----------------------------------------------------------------------------
module tsct_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  output logic               strobe_o,
  input  wire tsct_pkg::sts_t sts_i,
  output tsct_pkg::ctrl_t    ctrl_o
);
  import tsct_pkg::*;

  state_e state_q, state_d;
  logic   strobe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= ctrl_o.resp;
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign strobe_o = strobe_q;

  always_comb begin
    state_d       = state_q;
    ctrl_o.op     = DP_NOP;
    ctrl_o.resp   = 1'b0;
    ctrl_o.status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          ctrl_o.op = DP_LOAD;
          state_d   = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts_i.cmd)
          CMD_RECORD: begin
            if (sts_i.full) begin
              ctrl_o.resp   = 1'b1;
              ctrl_o.status = ST_FULL;
              state_d       = S_IDLE;
            end else if (sts_i.empty) begin
              ctrl_o.op   = DP_APPEND;
              ctrl_o.resp = 1'b1;
              state_d     = S_IDLE;
            end else begin
              ctrl_o.op = DP_RD_LAST;
              state_d   = S_LAST;
            end
          end
          CMD_FIND: begin
            ctrl_o.op = DP_SRCH_INIT;
            state_d   = S_SRCH;
          end
          CMD_CLEAR: begin
            ctrl_o.op   = DP_CLEAR;
            ctrl_o.resp = 1'b1;
            state_d     = S_IDLE;
          end
          default: begin
            ctrl_o.resp   = 1'b1;
            ctrl_o.status = ST_BAD_OP;
            state_d       = S_IDLE;
          end
        endcase
      end
      S_LAST: begin
        if (sts_i.older) begin
          ctrl_o.op = DP_SRCH_INIT;
          state_d   = S_SRCH;
        end else begin
          ctrl_o.op   = DP_APPEND;
          ctrl_o.resp = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_SRCH: begin
        if (!sts_i.srch_done) begin
          ctrl_o.op = DP_RD_MID;
          state_d   = S_SCHK;
        end else if (sts_i.cmd == CMD_RECORD) begin
          ctrl_o.op = DP_SH_START;
          state_d   = S_SHIFT;
        end else if (sts_i.lo_in) begin
          ctrl_o.op = DP_RD_LO;
          state_d   = S_FCHK;
        end else begin
          ctrl_o.resp   = 1'b1;
          ctrl_o.status = ST_NOT_FOUND;
          state_d       = S_IDLE;
        end
      end
      S_SCHK: begin
        ctrl_o.op = DP_SRCH_UPD;
        state_d   = S_SRCH;
      end
      S_SHIFT: begin
        ctrl_o.op = DP_SH_STEP;
        if (sts_i.sh_done) begin
          state_d = S_INSERT;
        end
      end
      S_INSERT: begin
        ctrl_o.op   = DP_INSERT;
        ctrl_o.resp = 1'b1;
        state_d     = S_IDLE;
      end
      S_FCHK: begin
        ctrl_o.resp = 1'b1;
        state_d     = S_IDLE;
        if (sts_i.tick_eq) begin
          ctrl_o.op = DP_FIND_HIT;
        end else begin
          ctrl_o.status = ST_NOT_FOUND;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/tsct_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tsct_dp
// Entry memory, fill count, search bounds, shift pointer and result registers.
// ----------------------------------------------------------------------------
module tsct_dp #(
  parameter int CAPACITY = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [1:0]        cmd_i,
  input  wire tsct_pkg::entry_t  entry_i,
  input  wire tsct_pkg::ctrl_t   ctrl_i,
  output tsct_pkg::sts_t         sts_o,
  output logic [1:0]             status_o,
  output tsct_pkg::entry_t       found_o,
  output logic [6:0]             count_o
);
  import tsct_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  entry_t           mem_q [CAPACITY];
  entry_t           rd_q;
  entry_t           req_q;
  cmd_e             cmd_q;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] lo_q, lo_d, hi_q, hi_d, mid_q;
  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] last;
  logic [IDX_W-1:0] sh_q, sh_d;
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  entry_t           wr_data;
  logic [1:0]       status_q;
  entry_t           found_q;
  logic [6:0]       count_q;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[CNT_W:1];
  assign last    = fill_q - CNT_W'(1);

  always_comb begin
    fill_d  = fill_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    sh_d    = sh_q;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    wr_addr = fill_q[IDX_W-1:0];
    rd_addr = last[IDX_W-1:0];
    wr_data = req_q;
    unique case (ctrl_i.op)
      DP_RD_LAST: rd_en = 1'b1;
      DP_SRCH_INIT: begin
        lo_d = '0;
        hi_d = fill_q;
      end
      DP_RD_MID: begin
        rd_en   = 1'b1;
        rd_addr = mid[IDX_W-1:0];
      end
      DP_SRCH_UPD: begin
        if (rd_q.tick < req_q.tick) begin
          lo_d = mid_q + CNT_W'(1);
        end else begin
          hi_d = mid_q;
        end
      end
      DP_SH_START: begin
        rd_en = 1'b1;
        sh_d  = last[IDX_W-1:0];
      end
      DP_SH_STEP: begin
        // move the entry read last cycle up one slot, fetch the next lower one unless the shift is done
        wr_en   = 1'b1;
        wr_addr = sh_q + IDX_W'(1);
        wr_data = rd_q;
        if (!sts_o.sh_done) begin
          rd_en   = 1'b1;
          rd_addr = sh_q - IDX_W'(1);
          sh_d    = sh_q - IDX_W'(1);
        end
      end
      DP_INSERT: begin
        wr_en   = 1'b1;
        wr_addr = lo_q[IDX_W-1:0];
        fill_d  = fill_q + CNT_W'(1);
      end
      DP_APPEND: begin
        wr_en  = 1'b1;
        fill_d = fill_q + CNT_W'(1);
      end
      DP_RD_LO: begin
        rd_en   = 1'b1;
        rd_addr = lo_q[IDX_W-1:0];
      end
      DP_CLEAR: fill_d = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    sh_q <= sh_d;
    if (ctrl_i.op == DP_RD_MID) begin
      mid_q <= mid;
    end
    if (ctrl_i.op == DP_LOAD) begin
      req_q <= entry_i;
      cmd_q <= cmd_e'(cmd_i);
    end
    if (ctrl_i.resp) begin
      status_q <= ctrl_i.status;
      found_q  <= (ctrl_i.op == DP_FIND_HIT) ? rd_q : '0;
      count_q  <= 7'(fill_d);
    end
  end

  assign sts_o.cmd       = cmd_q;
  assign sts_o.full      = (fill_q == CNT_W'(CAPACITY));
  assign sts_o.empty     = (fill_q == '0);
  assign sts_o.older     = (req_q.tick < rd_q.tick);
  assign sts_o.srch_done = (lo_q >= hi_q);
  assign sts_o.lo_in     = (lo_q < fill_q);
  assign sts_o.tick_eq   = (rd_q.tick == req_q.tick);
  assign sts_o.sh_done   = (sh_q == lo_q[IDX_W-1:0]);

  assign status_o = status_q;
  assign found_o  = found_q;
  assign count_o  = count_q;

endmodule
`default_nettype wire
